// ----- hw/rtl/ldr_pkg.sv -----
// shared types, constants and arithmetic helpers for the lens reprojection block
package ldr_pkg;

  // coordinate clip width for pixel and residual results
  localparam int COORD_WIDTH = 32;
  // working width for the unclipped pixel arithmetic
  localparam int CALC_W      = 50;
  // fraction bits of the normalized coordinates and coefficients
  localparam int FRAC        = 28;

  // divider: one prep stage, one stage per quotient bit, one finish stage
  localparam int QBITS    = 32;
  localparam int DIV_LAT  = QBITS + 2;
  // stages after the divider up to the output register
  localparam int POST_LAT = 11;
  localparam int PIPE_LAT = DIV_LAT + POST_LAT;

  localparam int CFG_IDX_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CX     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CY     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K1     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_K2     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_K3     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P1     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_P2     = 4'd7;

  localparam logic [30:0] FOCAL_RESET = 31'd65536;
  localparam logic signed [39:0] Q_ONE = 40'sd268435456;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [35:0] qprod_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic signed [31:0] seen_x;
    logic signed [31:0] seen_y;
  } ldr_in_t;

  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] residual_x;
    logic signed [31:0] residual_y;
    logic               behind_camera;
    logic               saturated;
  } ldr_out_t;

  // Q4.28 product, round half up
  function automatic qprod_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd134217728;
    return p[63:28];
  endfunction

  // clip to 32 bits signed
  function automatic q32_t sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [39:0] v);
    return (v > 40'sd2147483647) || (v < -40'sd2147483648);
  endfunction

  localparam logic signed [CALC_W-1:0] C_HI = CALC_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [CALC_W-1:0] C_LO = -C_HI - CALC_W'(1);

  // clip to the coordinate width
  function automatic coord_t cclip(input logic signed [CALC_W-1:0] v);
    if (v > C_HI) return C_HI[COORD_WIDTH-1:0];
    if (v < C_LO) return C_LO[COORD_WIDTH-1:0];
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic logic covf(input logic signed [CALC_W-1:0] v);
    return (v > C_HI) || (v < C_LO);
  endfunction

endpackage

// ----- hw/rtl/ldr_div.sv -----
// pipelined restoring divider: Q16.16 over Q16.16 to Q4.28, rounded, saturated
module ldr_div
  import ldr_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] num,
  input  logic signed [32:0] den,
  output q32_t               quo,
  output logic               ovf
);

  logic [32:0] mag;
  logic [60:0] dvd;
  logic        neg;

  logic [32:0]      rem_r [0:QBITS];
  logic [31:0]      lo_r  [0:QBITS];
  logic [QBITS-1:0] q_r   [0:QBITS];
  logic [32:0]      den_r [0:QBITS];
  logic             neg_r [0:QBITS];
  logic             big_r [0:QBITS];
  q32_t             quo_r;
  logic             ovf_r;

  // magnitude, shift and add half the divisor for rounding
  always_comb begin
    neg = num[32];
    mag = neg ? 33'(-num) : 33'(num);
    dvd = {mag, 28'd0} + 61'(den[32:1]);
  end

  // prep stage: top bits of the dividend become the first partial remainder
  always_ff @(posedge clk) begin
    rem_r[0] <= 33'(dvd[60:32]);
    lo_r[0]  <= dvd[31:0];
    q_r[0]   <= '0;
    den_r[0] <= den;
    neg_r[0] <= neg;
    big_r[0] <= 33'(dvd[60:32]) >= den;
  end

  // one quotient bit per stage
  for (genvar i = 1; i <= QBITS; i++) begin : g_step
    logic [33:0] t;
    logic        ge;
    always_comb begin
      t  = {rem_r[i-1], lo_r[i-1][31]};
      ge = t >= {1'b0, den_r[i-1]};
    end
    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? 33'(t - {1'b0, den_r[i-1]}) : t[32:0];
      lo_r[i]  <= {lo_r[i-1][30:0], 1'b0};
      q_r[i]   <= {q_r[i-1][QBITS-2:0], ge};
      den_r[i] <= den_r[i-1];
      neg_r[i] <= neg_r[i-1];
      big_r[i] <= big_r[i-1];
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (neg_r[QBITS]) begin
      if (big_r[QBITS] || q_r[QBITS] > 32'h8000_0000) begin
        quo_r <= 32'sh80000000;
        ovf_r <= 1'b1;
      end else begin
        quo_r <= -q_r[QBITS];
        ovf_r <= 1'b0;
      end
    end else begin
      if (big_r[QBITS] || q_r[QBITS][31]) begin
        quo_r <= 32'sh7fffffff;
        ovf_r <= 1'b1;
      end else begin
        quo_r <= q_r[QBITS];
        ovf_r <= 1'b0;
      end
    end
  end

  assign quo = quo_r;
  assign ovf = ovf_r;

endmodule

// ----- hw/rtl/lens_distortion_reprojection.sv -----
// lens distortion projection with reprojection residual, fully pipelined
//
//  channel  handshake            payload   notes
//  input    start / busy         in_data   taken when start high, busy low
//  result   out_valid strobe     out_data  one cycle, cannot be held off
//  config   cfg_valid/cfg_ready  cfg_*     index and data, only while idle
//
// one transaction per cycle while busy is low; each result follows its transaction
// through a 34 stage bit-per-stage divider, then 11 multiply/add stages.
// busy is a register that is set during reset and cleared once reset is released; cfg_ready is high.
// there is no stall path: valid bits simply follow the data down the pipe.
module lens_distortion_reprojection
  import ldr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ldr_in_t              in_data,
  output logic                 out_valid,
  output ldr_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef struct packed {
    logic        valid;
    logic        behind;
    logic        sat;
    q32_t        seen_x;
    q32_t        seen_y;
  } side_t;

  logic        busy_r;
  logic [30:0] focal_r;
  q32_t        cx_r, cy_r, k1_r, k2_r, k3_r, p1_r, p2_r;

  logic              accept;
  logic signed [32:0] px, py, pz;
  side_t             side_in;
  side_t             dl_r [0:DIV_LAT-1];
  q32_t              xn_q, yn_q;
  logic              xn_ovf, yn_ovf;

  // input ready after reset
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= FOCAL_RESET;
      cx_r <= '0; cy_r <= '0;
      k1_r <= '0; k2_r <= '0; k3_r <= '0;
      p1_r <= '0; p2_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL: focal_r <= cfg_data[30:0];
        REG_CX:    cx_r <= cfg_data;
        REG_CY:    cy_r <= cfg_data;
        REG_K1:    k1_r <= cfg_data;
        REG_K2:    k2_r <= cfg_data;
        REG_K3:    k3_r <= cfg_data;
        REG_P1:    p1_r <= cfg_data;
        REG_P2:    p2_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // camera frame point
  always_comb begin
    px = 33'(in_data.rotated_x) + 33'(in_data.shift_x);
    py = 33'(in_data.rotated_y) + 33'(in_data.shift_y);
    pz = 33'(in_data.rotated_z) + 33'(in_data.shift_z);
    side_in.valid  = accept;
    side_in.behind = pz <= 33'sd0;
    side_in.sat    = 1'b0;
    side_in.seen_x = in_data.seen_x;
    side_in.seen_y = in_data.seen_y;
  end

  ldr_div u_div_x (.clk(clk), .num(px), .den(pz), .quo(xn_q), .ovf(xn_ovf));
  ldr_div u_div_y (.clk(clk), .num(py), .den(pz), .quo(yn_q), .ovf(yn_ovf));

  // side data delay matched to the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) dl_r[i].valid <= 1'b0;
    end else begin
      dl_r[0].valid <= side_in.valid;
      for (int i = 1; i < DIV_LAT; i++) dl_r[i].valid <= dl_r[i-1].valid;
    end
    dl_r[0].behind <= side_in.behind;
    dl_r[0].sat    <= side_in.sat;
    dl_r[0].seen_x <= side_in.seen_x;
    dl_r[0].seen_y <= side_in.seen_y;
    for (int i = 1; i < DIV_LAT; i++) begin
      dl_r[i].behind <= dl_r[i-1].behind;
      dl_r[i].sat    <= dl_r[i-1].sat;
      dl_r[i].seen_x <= dl_r[i-1].seen_x;
      dl_r[i].seen_y <= dl_r[i-1].seen_y;
    end
  end

  side_t sd_a_r, sd_b_r, sd_c_r, sd_d_r, sd_e_r, sd_f_r, sd_g_r, sd_h_r, sd_i_r, sd_j_r;
  side_t sd_a_nxt, sd_b_nxt, sd_c_nxt, sd_d_nxt, sd_e_nxt, sd_f_nxt;
  side_t sd_h_nxt, sd_j_nxt;

  q32_t   xn_a_r, yn_a_r, x2_a_r, y2_a_r, xy_a_r;
  q32_t   xn_b_r, yn_b_r, x2_b_r, y2_b_r, xy_b_r, r2_b_r;
  q32_t   xn_c_r, yn_c_r, xy_c_r, r2_c_r, r4_c_r, tx_c_r, ty_c_r;
  qprod_t k1r2_c_r;
  q32_t   xn_d_r, yn_d_r, r6_d_r;
  qprod_t k1r2_d_r, k2r4_d_r, p1xy_d_r, p2xy_d_r, p2tx_d_r, p1ty_d_r;
  q32_t   xn_e_r, yn_e_r;
  qprod_t k1r2_e_r, k2r4_e_r, k3r6_e_r, p1xy_e_r, p2xy_e_r, p2tx_e_r, p1ty_e_r;
  q32_t   xn_f_r, yn_f_r, rc_f_r;
  qprod_t p1xy_f_r, p2xy_f_r, p2tx_f_r, p1ty_f_r;
  qprod_t xr_g_r, yr_g_r, p1xy_g_r, p2xy_g_r, p2tx_g_r, p1ty_g_r;
  q32_t   xd_h_r, yd_h_r;
  qprod_t fx_i_r, fy_i_r;
  coord_t ix_j_r, iy_j_r;

  logic          out_valid_r;
  ldr_out_t      out_r;

  qprod_t        m_xx, m_yy, m_xy, m_r4, m_r6;
  logic signed [39:0] s_r2, s_tx, s_ty, s_rc, s_xd, s_yd;
  logic signed [CALC_W-1:0] s_ix, s_iy, s_ex, s_ey;

  // squares and cross term
  always_comb begin
    m_xx = qmul(xn_q, xn_q);
    m_yy = qmul(yn_q, yn_q);
    m_xy = qmul(xn_q, yn_q);
    sd_a_nxt = dl_r[DIV_LAT-1];
    sd_a_nxt.sat = xn_ovf | yn_ovf | ovf32(40'(m_xx)) | ovf32(40'(m_yy)) | ovf32(40'(m_xy));
  end

  // radius squared
  always_comb begin
    s_r2 = 40'(x2_a_r) + 40'(y2_a_r);
    sd_b_nxt = sd_a_r;
    sd_b_nxt.sat = sd_a_r.sat | ovf32(s_r2);
  end

  // fourth power and tangential terms
  always_comb begin
    m_r4 = qmul(r2_b_r, r2_b_r);
    s_tx = 40'(r2_b_r) + 40'(x2_b_r) + 40'(x2_b_r);
    s_ty = 40'(r2_b_r) + 40'(y2_b_r) + 40'(y2_b_r);
    sd_c_nxt = sd_b_r;
    sd_c_nxt.sat = sd_b_r.sat | ovf32(40'(m_r4)) | ovf32(s_tx) | ovf32(s_ty);
  end

  // sixth power
  always_comb begin
    m_r6 = qmul(r4_c_r, r2_c_r);
    sd_d_nxt = sd_c_r;
    sd_d_nxt.sat = sd_c_r.sat | ovf32(40'(m_r6));
  end

  always_comb begin
    sd_e_nxt = sd_d_r;
  end

  // radial factor
  always_comb begin
    s_rc = Q_ONE + 40'(k1r2_e_r) + 40'(k2r4_e_r) + 40'(k3r6_e_r);
    sd_f_nxt = sd_e_r;
    sd_f_nxt.sat = sd_e_r.sat | ovf32(s_rc);
  end

  // distorted normalized point
  always_comb begin
    s_xd = 40'(xr_g_r) + 40'(p1xy_g_r) + 40'(p1xy_g_r) + 40'(p2tx_g_r);
    s_yd = 40'(yr_g_r) + 40'(p2xy_g_r) + 40'(p2xy_g_r) + 40'(p1ty_g_r);
    sd_h_nxt = sd_g_r;
    sd_h_nxt.sat = sd_g_r.sat | ovf32(s_xd) | ovf32(s_yd);
  end

  // pixel with principal point
  always_comb begin
    s_ix = CALC_W'(fx_i_r) + CALC_W'(cx_r);
    s_iy = CALC_W'(fy_i_r) + CALC_W'(cy_r);
    sd_j_nxt = sd_i_r;
    sd_j_nxt.sat = sd_i_r.sat | covf(s_ix) | covf(s_iy);
  end

  // residual
  always_comb begin
    s_ex = CALC_W'(ix_j_r) - CALC_W'(sd_j_r.seen_x);
    s_ey = CALC_W'(iy_j_r) - CALC_W'(sd_j_r.seen_y);
  end

  // pipeline registers, valid bits cleared in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_a_r.valid <= 1'b0; sd_b_r.valid <= 1'b0; sd_c_r.valid <= 1'b0;
      sd_d_r.valid <= 1'b0; sd_e_r.valid <= 1'b0; sd_f_r.valid <= 1'b0;
      sd_g_r.valid <= 1'b0; sd_h_r.valid <= 1'b0; sd_i_r.valid <= 1'b0;
      sd_j_r.valid <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      sd_a_r.valid <= sd_a_nxt.valid; sd_b_r.valid <= sd_b_nxt.valid;
      sd_c_r.valid <= sd_c_nxt.valid; sd_d_r.valid <= sd_d_nxt.valid;
      sd_e_r.valid <= sd_e_nxt.valid; sd_f_r.valid <= sd_f_nxt.valid;
      sd_g_r.valid <= sd_f_r.valid;   sd_h_r.valid <= sd_h_nxt.valid;
      sd_i_r.valid <= sd_h_r.valid;   sd_j_r.valid <= sd_j_nxt.valid;
      out_valid_r  <= sd_j_r.valid;
    end

    {sd_a_r.behind, sd_a_r.sat, sd_a_r.seen_x, sd_a_r.seen_y} <=
      {sd_a_nxt.behind, sd_a_nxt.sat, sd_a_nxt.seen_x, sd_a_nxt.seen_y};
    {sd_b_r.behind, sd_b_r.sat, sd_b_r.seen_x, sd_b_r.seen_y} <=
      {sd_b_nxt.behind, sd_b_nxt.sat, sd_b_nxt.seen_x, sd_b_nxt.seen_y};
    {sd_c_r.behind, sd_c_r.sat, sd_c_r.seen_x, sd_c_r.seen_y} <=
      {sd_c_nxt.behind, sd_c_nxt.sat, sd_c_nxt.seen_x, sd_c_nxt.seen_y};
    {sd_d_r.behind, sd_d_r.sat, sd_d_r.seen_x, sd_d_r.seen_y} <=
      {sd_d_nxt.behind, sd_d_nxt.sat, sd_d_nxt.seen_x, sd_d_nxt.seen_y};
    {sd_e_r.behind, sd_e_r.sat, sd_e_r.seen_x, sd_e_r.seen_y} <=
      {sd_e_nxt.behind, sd_e_nxt.sat, sd_e_nxt.seen_x, sd_e_nxt.seen_y};
    {sd_f_r.behind, sd_f_r.sat, sd_f_r.seen_x, sd_f_r.seen_y} <=
      {sd_f_nxt.behind, sd_f_nxt.sat, sd_f_nxt.seen_x, sd_f_nxt.seen_y};
    {sd_g_r.behind, sd_g_r.sat, sd_g_r.seen_x, sd_g_r.seen_y} <=
      {sd_f_r.behind, sd_f_r.sat, sd_f_r.seen_x, sd_f_r.seen_y};
    {sd_h_r.behind, sd_h_r.sat, sd_h_r.seen_x, sd_h_r.seen_y} <=
      {sd_h_nxt.behind, sd_h_nxt.sat, sd_h_nxt.seen_x, sd_h_nxt.seen_y};
    {sd_i_r.behind, sd_i_r.sat, sd_i_r.seen_x, sd_i_r.seen_y} <=
      {sd_h_r.behind, sd_h_r.sat, sd_h_r.seen_x, sd_h_r.seen_y};
    {sd_j_r.behind, sd_j_r.sat, sd_j_r.seen_x, sd_j_r.seen_y} <=
      {sd_j_nxt.behind, sd_j_nxt.sat, sd_j_nxt.seen_x, sd_j_nxt.seen_y};

    // stage a
    xn_a_r <= xn_q; yn_a_r <= yn_q;
    x2_a_r <= sat32(40'(m_xx)); y2_a_r <= sat32(40'(m_yy)); xy_a_r <= sat32(40'(m_xy));
    // stage b
    xn_b_r <= xn_a_r; yn_b_r <= yn_a_r; x2_b_r <= x2_a_r; y2_b_r <= y2_a_r;
    xy_b_r <= xy_a_r; r2_b_r <= sat32(s_r2);
    // stage c
    xn_c_r <= xn_b_r; yn_c_r <= yn_b_r; xy_c_r <= xy_b_r; r2_c_r <= r2_b_r;
    r4_c_r <= sat32(40'(m_r4)); tx_c_r <= sat32(s_tx); ty_c_r <= sat32(s_ty);
    k1r2_c_r <= qmul(k1_r, r2_b_r);
    // stage d
    xn_d_r <= xn_c_r; yn_d_r <= yn_c_r; r6_d_r <= sat32(40'(m_r6));
    k1r2_d_r <= k1r2_c_r;
    k2r4_d_r <= qmul(k2_r, r4_c_r);
    p1xy_d_r <= qmul(p1_r, xy_c_r);
    p2xy_d_r <= qmul(p2_r, xy_c_r);
    p2tx_d_r <= qmul(p2_r, tx_c_r);
    p1ty_d_r <= qmul(p1_r, ty_c_r);
    // stage e
    xn_e_r <= xn_d_r; yn_e_r <= yn_d_r;
    k1r2_e_r <= k1r2_d_r; k2r4_e_r <= k2r4_d_r; k3r6_e_r <= qmul(k3_r, r6_d_r);
    p1xy_e_r <= p1xy_d_r; p2xy_e_r <= p2xy_d_r; p2tx_e_r <= p2tx_d_r; p1ty_e_r <= p1ty_d_r;
    // stage f
    xn_f_r <= xn_e_r; yn_f_r <= yn_e_r; rc_f_r <= sat32(s_rc);
    p1xy_f_r <= p1xy_e_r; p2xy_f_r <= p2xy_e_r; p2tx_f_r <= p2tx_e_r; p1ty_f_r <= p1ty_e_r;
    // stage g
    xr_g_r <= qmul(xn_f_r, rc_f_r); yr_g_r <= qmul(yn_f_r, rc_f_r);
    p1xy_g_r <= p1xy_f_r; p2xy_g_r <= p2xy_f_r; p2tx_g_r <= p2tx_f_r; p1ty_g_r <= p1ty_f_r;
    // stage h
    xd_h_r <= sat32(s_xd); yd_h_r <= sat32(s_yd);
    // stage i
    fx_i_r <= qmul({1'b0, focal_r}, xd_h_r);
    fy_i_r <= qmul({1'b0, focal_r}, yd_h_r);
    // stage j
    ix_j_r <= cclip(s_ix); iy_j_r <= cclip(s_iy);
    // output register, zeroed when the point is behind the camera
    if (sd_j_r.behind) begin
      out_r.proj_x        <= '0;
      out_r.proj_y        <= '0;
      out_r.residual_x    <= '0;
      out_r.residual_y    <= '0;
      out_r.behind_camera <= 1'b1;
      out_r.saturated     <= 1'b0;
    end else begin
      out_r.proj_x        <= 32'(ix_j_r);
      out_r.proj_y        <= 32'(iy_j_r);
      out_r.residual_x    <= 32'(cclip(s_ex));
      out_r.residual_y    <= 32'(cclip(s_ey));
      out_r.behind_camera <= 1'b0;
      out_r.saturated     <= sd_j_r.sat | covf(s_ex) | covf(s_ey);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/ldr_checker.sv -----
// port level checks for the lens reprojection block, bound to the top level
module ldr_checker
  import ldr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input ldr_out_t out_data
);

  logic [5:0] warm_r;

  // cycles since reset, so history checks skip the fill period
  always_ff @(posedge clk) begin
    if (!rst_n) warm_r <= '0;
    else if (warm_r != 6'(PIPE_LAT + 2)) warm_r <= warm_r + 6'd1;
  end

  // every accepted transaction gives one result, and every result has an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm_r == 6'(PIPE_LAT + 2) |-> out_valid == $past(start && !busy, PIPE_LAT))
    else $error("result strobe does not match accepted transactions");

  // a point behind the camera gives zero values and no clip flag
  a_behind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.behind_camera |->
      out_data.proj_x == 32'sd0 && out_data.proj_y == 32'sd0 &&
      out_data.residual_x == 32'sd0 && out_data.residual_y == 32'sd0 &&
      !out_data.saturated)
    else $error("behind camera result not zeroed");

  // input is always open once out of reset
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    warm_r != 6'd0 |-> !busy)
    else $error("busy raised outside reset");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind lens_distortion_reprojection ldr_checker u_ldr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the lens distortion reprojection block
`timescale 1ns / 1ps

module testbench;
  import ldr_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  ldr_in_t              in_data;
  logic                 out_valid;
  ldr_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  lens_distortion_reprojection dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // camera model copy held by the predictor
  longint lens_focal, lens_cx, lens_cy, lens_k1, lens_k2, lens_k3, lens_p1, lens_p2;
  bit     clip_hit;

  ldr_in_t  point_queue[$];
  ldr_out_t pixel_queue[$];
  int       idle_pct;
  int       mismatches;
  bit       in_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // floor of t / 2^s
  function automatic longint shr_floor(longint t, int s);
    return t >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) begin
      clip_hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip_hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint r32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint pix(longint v);
    longint hi;
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    return clamp(v, -hi - 1, hi);
  endfunction

  function automatic longint qprod(longint a, longint b);
    return shr_floor(a * b + (64'sd1 <<< 27), FRAC);
  endfunction

  // rounded Q4.28 quotient, half away from zero
  function automatic longint qquot(longint num, longint den);
    longint unsigned mag, q;
    mag = longint'(num < 0 ? -num : num) << FRAC;
    q = (mag + (den >> 1)) / den;
    if (num < 0) begin
      if (q > (64'd1 << 31)) begin
        clip_hit = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'd2147483647) begin
      clip_hit = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic ldr_out_t project_point(ldr_in_t p);
    ldr_out_t r;
    longint px, py, pz, xn, yn, x2, y2, xy, r2, r4, r6, rc, xd, yd, ix, iy, ex, ey;
    px = longint'(p.rotated_x) + longint'(p.shift_x);
    py = longint'(p.rotated_y) + longint'(p.shift_y);
    pz = longint'(p.rotated_z) + longint'(p.shift_z);
    clip_hit = 1'b0;
    r = '0;
    if (pz <= 0) begin
      r.behind_camera = 1'b1;
      return r;
    end
    xn = qquot(px, pz);
    yn = qquot(py, pz);
    x2 = r32(qprod(xn, xn));
    y2 = r32(qprod(yn, yn));
    xy = r32(qprod(xn, yn));
    r2 = r32(x2 + y2);
    r4 = r32(qprod(r2, r2));
    r6 = r32(qprod(r4, r2));
    rc = r32((64'sd1 <<< FRAC) + qprod(lens_k1, r2) + qprod(lens_k2, r4)
             + qprod(lens_k3, r6));
    xd = r32(qprod(xn, rc) + 2 * qprod(lens_p1, xy) + qprod(lens_p2, r32(r2 + 2 * x2)));
    yd = r32(qprod(yn, rc) + 2 * qprod(lens_p2, xy) + qprod(lens_p1, r32(r2 + 2 * y2)));
    ix = pix(qprod(lens_focal, xd) + lens_cx);
    iy = pix(qprod(lens_focal, yd) + lens_cy);
    ex = pix(ix - longint'(p.seen_x));
    ey = pix(iy - longint'(p.seen_y));
    r.proj_x     = ix[31:0];
    r.proj_y     = iy[31:0];
    r.residual_x = ex[31:0];
    r.residual_y = ey[31:0];
    r.saturated  = clip_hit;
    return r;
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    case (idx)
      REG_FOCAL: lens_focal = longint'({1'b0, v[30:0]});
      REG_CX:    lens_cx = longint'(signed'(v));
      REG_CY:    lens_cy = longint'(signed'(v));
      REG_K1:    lens_k1 = longint'(signed'(v));
      REG_K2:    lens_k2 = longint'(signed'(v));
      REG_K3:    lens_k3 = longint'(signed'(v));
      REG_P1:    lens_p1 = longint'(signed'(v));
      REG_P2:    lens_p2 = longint'(signed'(v));
      default: ;
    endcase
  endfunction

  // predictor: note each accepted transaction and queue its expected result
  always @(posedge clk) begin
    in_taken = rst_n && start && !busy;
    if (in_taken) pixel_queue = {pixel_queue, project_point(in_data)};
  end

  // driver: hold the item until taken, then load the next one or go idle
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      if (point_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data <= point_queue.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    ldr_out_t want;
    if (rst_n && out_valid) begin
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pixel_queue.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h got %h", want, out_data);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(4) - 2;
      default: return $urandom();
    endcase
  endfunction

  // well-formed point in front of the camera, random content elsewhere
  function automatic ldr_in_t rand_point();
    ldr_in_t p;
    int sel;
    sel = $urandom_range(9);
    p.rotated_x = (sel < 7) ? ($urandom_range(32'h00ffffff) - 32'h007fffff) : rand_word();
    p.rotated_y = (sel < 7) ? ($urandom_range(32'h00ffffff) - 32'h007fffff) : rand_word();
    p.rotated_z = (sel < 7) ? $urandom_range(32'h01000000, 32'h00010000) : rand_word();
    p.shift_x   = (sel < 7) ? ($urandom_range(32'h0003ffff) - 32'h0001ffff) : rand_word();
    p.shift_y   = (sel < 7) ? ($urandom_range(32'h0003ffff) - 32'h0001ffff) : rand_word();
    p.shift_z   = (sel < 7) ? $urandom_range(32'h00020000) : rand_word();
    p.seen_x    = (sel < 8) ? ($urandom_range(32'h07ffffff) - 32'h03ffffff) : rand_word();
    p.seen_y    = (sel < 8) ? ($urandom_range(32'h07ffffff) - 32'h03ffffff) : rand_word();
    return p;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    model_write(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (point_queue.size() == 0 && !start);
    wait (pixel_queue.size() == 0);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  // lens settings: identity, typical lens, extremes, or random
  task automatic set_lens(int mode);
    logic [31:0] v[8];
    case (mode)
      0: v = '{32'h00010000, 0, 0, 0, 0, 0, 0, 0};
      1: v = '{32'h03200000, 32'h01400000, 32'h00f00000, 32'hfd000000, 32'h00800000,
               32'hffe00000, 32'h00040000, 32'hfffc0000};
      2: v = '{32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h7fffffff, 32'h80000000, 32'h7fffffff};
      3: v = '{32'h00000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h80000000};
      default: for (int i = 0; i < 8; i++) v[i] = $urandom();
    endcase
    for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), v[i]);
    // indexes past the list are ignored
    write_reg(4'd8 + CFG_IDX_W'($urandom_range(7)), $urandom());
  endtask

  task automatic push_directed();
    ldr_in_t p;
    logic [31:0] ext[4] = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
    for (int i = 0; i < 4; i++) begin
      p = '{ext[i], ext[3-i], ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4],
            ext[i], ext[3-i]};
      point_queue = {point_queue, p};
    end
    // depth exactly zero, negative, and smallest positive
    p = '{32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 32'hffff0000, 0, 0};
    point_queue = {point_queue, p};
    p.shift_z = 32'hfffe0000;
    point_queue = {point_queue, p};
    p.rotated_z = 32'h00000001;
    p.shift_z   = 0;
    point_queue = {point_queue, p};
    // on-axis point and a large off-axis point
    p = '{0, 0, 32'h00010000, 0, 0, 0, 32'h00008000, 32'hffff8000};
    point_queue = {point_queue, p};
    p = '{32'h7fff0000, 32'h80000000, 32'h00000002, 32'h7fffffff, 32'h80000000, 0, 0, 0};
    point_queue = {point_queue, p};
  endtask

  // lens written first, with the pipe empty, then the items of the phase
  task automatic run_phase(int lens, int n, bit directed);
    set_lens(lens);
    if (directed) push_directed();
    for (int i = 0; i < n; i++) point_queue = {point_queue, rand_point()};
    drain();
  endtask

  initial begin
    lens_focal = 65536;
    {lens_cx, lens_cy, lens_k1, lens_k2, lens_k3, lens_p1, lens_p2} = '0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    idle_pct = 24;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    push_directed();
    drain();
    for (int ph = 0; ph < 5; ph++) run_phase(ph, 100, 1'b1);
    idle_pct = 79;
    for (int ph = 0; ph < 5; ph++) run_phase((ph + 2) % 5, 100, 1'b0);
    idle_pct = 0;
    for (int ph = 0; ph < 5; ph++) run_phase((ph + 1) % 5, 100, 1'b0);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
